// File: rtl/lfys_pkg.sv
// ============================================================================
// lfys_pkg: shared constants and types for the card shuffler
// Table geometry, generator constants, and the random-unit request/response structs.
// ============================================================================
package lfys_pkg;

  localparam int MaxCards  = 512;
  localparam int AddrW     = $clog2(MaxCards);
  localparam int EntryW    = AddrW;
  localparam int CardW     = 9;
  localparam int CountW    = 10;
  localparam int SeedW     = 64;
  localparam int RandW     = 31;
  localparam int LcgShift  = 33;

  localparam logic [63:0] LcgMul = 64'd6364136223846793005;
  localparam logic [63:0] LcgInc = 64'd1442695040888963407;

  localparam logic OpShuffle = 1'b0;
  localparam logic OpRead    = 1'b1;

  localparam logic CfgSeed  = 1'b0;
  localparam logic CfgCount = 1'b1;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;

  // Random-number unit request/response.
  typedef struct packed {
    logic             start;
    logic [AddrW:0]   bound;  // i + 1
  } rng_req_t;

  typedef struct packed {
    logic             done;
    logic [AddrW-1:0] pick;   // r mod bound
  } rng_rsp_t;

endpackage

// File: rtl/lfys_rng.sv
// ============================================================================
// lfys_rng: LCG step and modulo reduction
// Advances the 64-bit generator with a partial-product multiplier (three
// 32x32 products), then reduces bits 63..33 modulo the bound by
// restoring division, one bit per cycle.
// ============================================================================
module lfys_rng (
  input  logic              clk,
  input  logic              rst,
  input  lfys_pkg::rng_req_t req,
  input  logic              load,   // load the seed into the generator
  input  logic [63:0]       load_seed,
  output lfys_pkg::rng_rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ADD  = 4'b0100,
    S_DIV  = 4'b1000
  } rng_state_t;

  rng_state_t  state;
  logic [63:0] gen;
  logic [63:0] acc;
  logic [1:0]  part;
  logic [63:0] prod;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [lfys_pkg::RandW-1:0] quo;
  logic [lfys_pkg::AddrW:0]   rem;
  logic [lfys_pkg::AddrW:0]   bound;
  logic [4:0]                 bit_cnt;
  logic [lfys_pkg::AddrW+1:0] trial;
  logic [lfys_pkg::AddrW:0]   rem_fin;

  // Only low 64 bits are kept, so hi*hi is skipped: parts lo*lo, lo*hi, hi*lo.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (part)
      2'd0: begin mul_a = gen[31:0];  mul_b = lfys_pkg::LcgMul[31:0];  end
      2'd1: begin mul_a = gen[31:0];  mul_b = lfys_pkg::LcgMul[63:32]; end
      2'd2: begin mul_a = gen[63:32]; mul_b = lfys_pkg::LcgMul[31:0];  end
      default: begin mul_a = 32'd0;   mul_b = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign trial = {rem, quo[lfys_pkg::RandW-1]} - {1'b0, bound};

  assign rem_fin = (!trial[lfys_pkg::AddrW+1]) ? trial[lfys_pkg::AddrW:0]
                 : {rem[lfys_pkg::AddrW-1:0], quo[lfys_pkg::RandW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      gen      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (load) gen <= load_seed;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            state <= S_MUL;
            part  <= 2'd0;
            acc   <= lfys_pkg::LcgInc;
            bound <= req.bound;
          end
        end
        S_MUL: begin
          // prod holds the product from the previous part
          if (part != 2'd0) begin
            case (part)
              2'd1:    acc <= acc + prod;
              2'd2:    acc <= acc + {prod[31:0], 32'd0};
              2'd3:    acc <= acc + {prod[31:0], 32'd0};
              default: acc <= acc;
            endcase
          end
          part <= part + 2'd1;
          if (part == 2'd3) state <= S_ADD;
        end
        S_ADD: begin
          gen     <= acc;
          quo     <= acc[63:lfys_pkg::LcgShift];
          rem     <= '0;
          bit_cnt <= 5'd0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (!trial[lfys_pkg::AddrW+1]) begin
            rem <= trial[lfys_pkg::AddrW:0];
          end else begin
            rem <= {rem[lfys_pkg::AddrW-1:0], quo[lfys_pkg::RandW-1]};
          end
          quo     <= {quo[lfys_pkg::RandW-2:0], 1'b0};
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'(lfys_pkg::RandW - 1)) begin
            state    <= S_IDLE;
            rsp.done <= 1'b1;
            rsp.pick <= rem_fin[lfys_pkg::AddrW-1:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/lcg_fisher_yates_shuffle.sv
// ============================================================================
// lcg_fisher_yates_shuffle: deterministic card-order shuffler
// Permutation table in block RAM, shuffled by Fisher-Yates with a 64-bit LCG.
// ============================================================================
// After reset the block sweeps the table to identity with s_tready low.
// A read item passes through the transfer in ST_IDLE, ST_RD to issue the
// table read, and ST_OUT for the registered RAM output while the result
// is loaded; the result shows on the master side in the next cycle,
// when the next input transfer can already take place. A shuffle first
// sweeps the whole table back to identity and then handles each position
// from the saturated card count minus one down to 1: it starts the
// generator, runs the multi-cycle LCG multiply and the bit-serial modulo,
// hands the pick over, and does the swap through the single RAM read
// port. The result register lets a finished result wait for the
// consumer; a new item is accepted once the previous one has been
// handed over to that register and no result is stalled.
module lcg_fisher_yates_shuffle (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [8:0] position
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [8:0] card
  output logic        m_tuser,   // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW = lfys_pkg::AddrW;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CLEAR = 10'b0000000010,
    ST_RAND  = 10'b0000000100,
    ST_WAIT  = 10'b0000001000,
    ST_RDJ   = 10'b0000010000,
    ST_LATJ  = 10'b0000100000,
    ST_WRI   = 10'b0001000000,
    ST_WRJ   = 10'b0010000000,
    ST_RD    = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  logic [63:0]            seed;
  logic [lfys_pkg::CountW-1:0] card_count;
  logic [AW:0]            eff_count;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          pos;
  logic [lfys_pkg::EntryW-1:0] mem [lfys_pkg::MaxCards];
  logic [lfys_pkg::EntryW-1:0] rd_data;
  logic [lfys_pkg::EntryW-1:0] val_i;
  logic [lfys_pkg::EntryW-1:0] val_j;
  logic [AW-1:0]          pick;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [lfys_pkg::EntryW-1:0] wdata;
  logic                   out_status;
  logic                   is_read;
  logic                   init;
  lfys_pkg::rng_req_t     rreq;
  lfys_pkg::rng_rsp_t     rrsp;
  logic                   load;

  assign eff_count = (card_count > 10'(lfys_pkg::MaxCards))
                   ? (AW+1)'(lfys_pkg::MaxCards) : card_count[AW:0];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= '0;
      card_count <= 10'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        lfys_pkg::CfgSeed:  seed       <= cfg_data;
        lfys_pkg::CfgCount: card_count <= cfg_data[lfys_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Table RAM: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  assign s_tready = (state == ST_IDLE) && !(m_tvalid && !m_tready);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = idx;
    raddr = idx;
    case (state)
      ST_CLEAR: begin we = 1'b1; waddr = idx; wdata = idx; end
      ST_RDJ:   raddr = pick;
      ST_WRI:   begin we = 1'b1; waddr = idx;  wdata = val_j; end
      ST_WRJ:   begin we = 1'b1; waddr = pick; wdata = val_i; end
      ST_RD:    raddr = pos;
      ST_OUT:   raddr = pos;   // hold the read data while the result waits
      default: ;
    endcase
  end

  assign rreq.start = (state == ST_RAND);
  assign rreq.bound = {1'b0, idx} + (AW+1)'(1);
  assign pick       = rrsp.pick;

  lfys_rng u_rng (
    .clk(clk), .rst(rst), .req(rreq), .load(load),
    .load_seed(seed), .rsp(rrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      init     <= 1'b1;
      m_tvalid <= 1'b0;
      load     <= 1'b0;
      idx      <= '0;
      pos      <= '0;
      val_i    <= '0;
      val_j    <= '0;
      is_read  <= 1'b0;
      out_status <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= 1'b0;
    end else begin
      load <= 1'b0;
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            pos <= s_tdata[AW-1:0];
            if (s_tuser == lfys_pkg::OpShuffle) begin
              idx   <= '0;
              load  <= 1'b1;
              state <= ST_CLEAR;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_CLEAR: begin
          // sweep back to identity over the whole table
          if (idx == AW'(lfys_pkg::MaxCards - 1)) begin
            if (init) begin
              // table fill after reset: no result
              init  <= 1'b0;
              state <= ST_IDLE;
            end else if (eff_count < (AW+1)'(2)) begin
              is_read <= 1'b0; out_status <= lfys_pkg::StatusOk;
              state <= ST_OUT;
            end else begin
              idx   <= AW'(eff_count - (AW+1)'(1));
              state <= ST_RAND;
            end
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_RAND: state <= ST_WAIT;
        ST_WAIT: if (rrsp.done) state <= ST_RDJ;
        ST_RDJ: begin
          val_i <= rd_data;   // read of idx issued in ST_WAIT
          state <= ST_LATJ;
        end
        ST_LATJ: begin
          val_j <= rd_data;   // read of pick issued in ST_RDJ
          state <= ST_WRI;
        end
        ST_WRI: state <= ST_WRJ;
        ST_WRJ: begin
          if (idx == AW'(1)) begin
            is_read <= 1'b0; out_status <= lfys_pkg::StatusOk;
            state <= ST_OUT;
          end else begin
            idx   <= idx - AW'(1);
            state <= ST_RAND;
          end
        end
        ST_RD: begin
          is_read    <= 1'b1;
          out_status <= ({1'b0, pos} >= eff_count) ? lfys_pkg::StatusRange
                                                   : lfys_pkg::StatusOk;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0,
                         (is_read && out_status == lfys_pkg::StatusOk)
                         ? rd_data[lfys_pkg::CardW-1:0] : 9'd0};
            m_tuser  <= out_status;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(m_tuser) && m_tvalid)
    else $error("result changed");

endmodule

// File: tb/lcg_fisher_yates_shuffle_tb.sv
// ============================================================================
// lcg_fisher_yates_shuffle_tb: self-checking bench for the card shuffler
// Drives shuffle and read transfers over the stream ports, programs the seed
// and card count between phases, and checks every result against a
// behavioral shuffler kept in the bench.
// ============================================================================
module lcg_fisher_yates_shuffle_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [8:0] position
  logic        s_tuser = lfys_pkg::OpShuffle;   // [0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [8:0] card
  logic        m_tuser;        // [0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = lfys_pkg::CfgSeed;
  logic [63:0] cfg_data = '0;

  lcg_fisher_yates_shuffle uut (.*);

  always #6 clk = ~clk;

  // Bench copy of the block state.
  logic [lfys_pkg::SeedW-1:0]  deck_seed;
  logic [lfys_pkg::CountW-1:0] deck_count;
  logic [8:0]                  deck[lfys_pkg::MaxCards];
  logic [lfys_pkg::SeedW-1:0]  lcg_state;

  typedef struct packed {
    logic [lfys_pkg::CardW-1:0] card;
    logic                       status;
  } card_result_t;

  card_result_t pending_cards[$];
  int errors;
  int n_shuffles, n_reads, n_range, n_results;
  int stall_cycles = 0;
  bit sink_busy;   // receiver stalls allowed
  int idle_run = 0;

  function automatic int short_or_long();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic int eff_count();
    return (deck_count > lfys_pkg::MaxCards) ? lfys_pkg::MaxCards : deck_count;
  endfunction

  // Rebuild the deck exactly as the block does on a shuffle transfer.
  task automatic shuffle_deck();
    int n, i, j;
    logic [8:0] t;
    logic [30:0] r;
    n = eff_count();
    for (i = 0; i < lfys_pkg::MaxCards; i++) deck[i] = i[8:0];
    lcg_state = deck_seed;
    for (i = n - 1; i > 0; i--) begin
      lcg_state = lcg_state * lfys_pkg::LcgMul + lfys_pkg::LcgInc;
      r = lcg_state[63:lfys_pkg::LcgShift];
      j = int'(r) % (i + 1);
      t = deck[i]; deck[i] = deck[j]; deck[j] = t;
    end
  endtask

  function automatic card_result_t predict(logic op, logic [8:0] pos);
    card_result_t res;
    res = '{card: '0, status: lfys_pkg::StatusOk};
    if (op == lfys_pkg::OpShuffle) return res;
    if (int'(pos) >= eff_count()) res.status = lfys_pkg::StatusRange;
    else res.card = deck[pos];
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  // Send one item; valid goes low between transfers.
  task automatic send_item(logic op, logic [8:0] pos);
    int gap;
    gap = short_or_long();
    repeat (gap + 1) @(posedge clk);
    if (op == lfys_pkg::OpShuffle) begin
      shuffle_deck();
      n_shuffles++;
    end else begin
      n_reads++;
      if (int'(pos) >= eff_count()) n_range++;
    end
    pending_cards.push_back(predict(op, pos));
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, pos};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    s_tvalid <= 1'b0;
    s_tdata  <= 16'($urandom) & 16'h01ff;
    s_tuser  <= 1'($urandom);
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == lfys_pkg::CfgSeed) deck_seed = val;
    else deck_count = val[lfys_pkg::CountW-1:0];
    @(posedge clk);
  endtask

  // Wait for all results, then let the block settle before touching registers.
  task automatic drain();
    while (pending_cards.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: random stalls on tready, compare each transfer.
  always @(posedge clk) begin
    card_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (pending_cards.size() == 0) begin
          report("unexpected result", m_tdata, -1);
        end else begin
          want = pending_cards.pop_front();
          if (m_tdata[8:0] != want.card) report("card", m_tdata[8:0], want.card);
          if (m_tuser != want.status) report("status", m_tuser, want.status);
        end
      end
      if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        m_tready <= 1'b0;
      end else if (sink_busy && $urandom_range(0, 3) == 0) begin
        stall_cycles <= short_or_long();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: idle cycles without any transfer.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run > 200000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_reset_state();
    send_item(lfys_pkg::OpRead, 9'd0);
    send_item(lfys_pkg::OpRead, 9'd1);
    send_item(lfys_pkg::OpRead, 9'd2);
    send_item(lfys_pkg::OpRead, 9'd511);
    drain();
  endtask

  task automatic test_directed();
    write_reg(lfys_pkg::CfgSeed, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(lfys_pkg::CfgCount, 64'd512);
    send_item(lfys_pkg::OpShuffle, 9'h1ff);
    send_item(lfys_pkg::OpRead, 9'd0);
    send_item(lfys_pkg::OpRead, 9'd511);
    send_item(lfys_pkg::OpRead, 9'h155);
    send_item(lfys_pkg::OpRead, 9'h0aa);
    drain();
    // Seed change alone leaves the deck as is.
    write_reg(lfys_pkg::CfgSeed, 64'd0);
    send_item(lfys_pkg::OpRead, 9'd511);
    drain();
    write_reg(lfys_pkg::CfgCount, 64'h3ff);   // saturates at table size
    send_item(lfys_pkg::OpShuffle, 9'd0);
    send_item(lfys_pkg::OpRead, 9'd511);
    drain();
    write_reg(lfys_pkg::CfgCount, 64'd0);
    send_item(lfys_pkg::OpShuffle, 9'd3);
    send_item(lfys_pkg::OpRead, 9'd0);
    drain();
    write_reg(lfys_pkg::CfgCount, 64'd1);
    send_item(lfys_pkg::OpShuffle, 9'd0);
    send_item(lfys_pkg::OpRead, 9'd0);
    send_item(lfys_pkg::OpRead, 9'd1);
    drain();
    write_reg(lfys_pkg::CfgCount, 64'd2);
    write_reg(lfys_pkg::CfgSeed, 64'h8000_0000_0000_0001);
    send_item(lfys_pkg::OpShuffle, 9'd0);
    send_item(lfys_pkg::OpRead, 9'd0);
    send_item(lfys_pkg::OpRead, 9'd1);
    send_item(lfys_pkg::OpRead, 9'd2);
    drain();
  endtask

  // Random phases: mostly small decks, reads dominate, shuffles sprinkled in.
  task automatic test_random();
    int ph, k, items;
    logic [8:0] pos;
    for (ph = 0; ph < 18; ph++) begin
      write_reg(lfys_pkg::CfgSeed, {$urandom, $urandom});
      if (ph % 9 == 4) write_reg(lfys_pkg::CfgCount, 64'($urandom_range(500, 1023)));
      else write_reg(lfys_pkg::CfgCount, 64'($urandom_range(0, 40)));
      sink_busy = (ph % 5 != 2);
      items = 25;
      for (k = 0; k < items; k++) begin
        if ($urandom_range(0, 9) == 0 || k == 0) begin
          send_item(lfys_pkg::OpShuffle, 9'($urandom));
        end else begin
          if ($urandom_range(0, 3) == 0) pos = 9'($urandom);
          else pos = 9'($urandom_range(0, eff_count() > 0 ? eff_count() - 1 : 0));
          send_item(lfys_pkg::OpRead, pos);
        end
        if (k == 12 && ph == 3) drain();   // sender waits for everything
      end
      drain();
    end
  endtask

  initial begin
    errors = 0; n_shuffles = 0; n_reads = 0; n_range = 0; n_results = 0;
    sink_busy = 1'b1;
    deck_seed = '0; deck_count = 10'd2; lcg_state = '0;
    for (int i = 0; i < lfys_pkg::MaxCards; i++) deck[i] = i[8:0];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d shuffles and %0d reads (%0d out of range), %0d results checked",
             n_shuffles, n_reads, n_range, n_results);
    if (errors == 0 && pending_cards.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
